// File: src/ppfc_pkg.sv
// shared types and constants for the point projection and frustum cull block
package ppfc_pkg;

  localparam int REG_W    = 63;
  localparam int SIZE_W   = 13;
  localparam int GROUND_W = 16;
  localparam int QUOT_W   = 13;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;
  localparam int MAC_STEPS = 9;

  localparam logic [SIZE_W-1:0]          WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0]          HEIGHT_RESET = 13'd480;
  localparam logic signed [GROUND_W-1:0] GROUND_RESET = -16'sd358;

  typedef enum logic [IDX_W-1:0] {
    CFG_COEFF0 = 3'd0,
    CFG_COEFF1 = 3'd1,
    CFG_COEFF2 = 3'd2,
    CFG_OFFSET = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5,
    CFG_GF_ON  = 3'd6,
    CFG_GROUND = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][REG_W-1:0] coeff;
    logic [REG_W-1:0]      offset;
    logic [SIZE_W-1:0]     width;
    logic [SIZE_W-1:0]     height;
    logic                  gf_on;
    logic [GROUND_W-1:0]   ground;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_row;
    logic [1:0] mul_col;
    logic       div_init;
    logic       div_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_DSET = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

// File: src/ppfc_regs.sv
// configuration register file
module ppfc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ppfc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [ppfc_pkg::REG_W-1:0]  cfg_data_i,
  output ppfc_pkg::cfg_t              cfg_o,
  output logic                        restart_o
);

  ppfc_pkg::cfg_t cfg_q, cfg_d;
  logic           restart_q, restart_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ppfc_pkg::cfg_idx_e'(cfg_idx_i))
        ppfc_pkg::CFG_COEFF0: cfg_d.coeff[0] = cfg_data_i;
        ppfc_pkg::CFG_COEFF1: cfg_d.coeff[1] = cfg_data_i;
        ppfc_pkg::CFG_COEFF2: cfg_d.coeff[2] = cfg_data_i;
        ppfc_pkg::CFG_OFFSET: cfg_d.offset   = cfg_data_i;
        ppfc_pkg::CFG_WIDTH:  cfg_d.width    = cfg_data_i[ppfc_pkg::SIZE_W-1:0];
        ppfc_pkg::CFG_HEIGHT: cfg_d.height   = cfg_data_i[ppfc_pkg::SIZE_W-1:0];
        ppfc_pkg::CFG_GF_ON:  cfg_d.gf_on    = cfg_data_i[0];
        ppfc_pkg::CFG_GROUND: cfg_d.ground   = cfg_data_i[ppfc_pkg::GROUND_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // row restart follows the height write so it sees the new height
  assign restart_d = cfg_we_i &&
                     (ppfc_pkg::cfg_idx_e'(cfg_idx_i) == ppfc_pkg::CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff  <= '0;
      cfg_q.offset <= '0;
      cfg_q.width  <= ppfc_pkg::WIDTH_RESET;
      cfg_q.height <= ppfc_pkg::HEIGHT_RESET;
      cfg_q.gf_on  <= 1'b1;
      cfg_q.ground <= ppfc_pkg::GROUND_RESET;
      restart_q    <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      restart_q <= restart_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = restart_q;

endmodule

// File: src/ppfc_ctrl.sv
// sequencer for load, multiply-accumulate, divide and result hand-off
module ppfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppfc_pkg::status_t status_i,
  output ppfc_pkg::cmd_t    cmd_o
);

  ppfc_pkg::state_e             state_q, state_d;
  logic [ppfc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]                   row_q, row_d;
  logic [1:0]                   col_q, col_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.mul_row = row_q;
    cmd_o.mul_col = col_q;
    case (state_q)
      ppfc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          row_d      = '0;
          col_d      = '0;
          state_d    = ppfc_pkg::ST_MAC;
        end
      end
      ppfc_pkg::ST_MAC: begin
        // last count only drains the product register
        if (cnt_q == ppfc_pkg::CNT_W'(ppfc_pkg::MAC_STEPS)) begin
          state_d = ppfc_pkg::ST_DSET;
        end else begin
          cmd_o.mul_en = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          if (col_q == 2'd2) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ppfc_pkg::ST_DSET: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ppfc_pkg::ST_DIV;
      end
      ppfc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == ppfc_pkg::CNT_W'(ppfc_pkg::QUOT_W - 1)) begin
          state_d = ppfc_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ppfc_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ppfc_pkg::ST_IDLE;
        end
      end
      default: state_d = ppfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppfc_pkg::ST_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assign in_ready_o = (state_q == ppfc_pkg::ST_IDLE);

endmodule

// File: src/ppfc_dp.sv
// datapath: ground test, shared multiplier, two quotient lanes, row tracking
module ppfc_dp #(
  parameter int COORD_WIDTH = 16,
  parameter int COEFF_WIDTH = 21,
  parameter int PIXEL_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppfc_pkg::cfg_t                cfg_i,
  input  logic                          restart_i,
  input  ppfc_pkg::cmd_t                cmd_i,
  output ppfc_pkg::status_t             status_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          kept_o,
  output logic                          in_view_o,
  output logic [PIXEL_WIDTH-1:0]        pixel_col_o,
  output logic [PIXEL_WIDTH-1:0]        pixel_row_o,
  output logic [PIXEL_WIDTH-1:0]        top_row_o,
  output logic [PIXEL_WIDTH-1:0]        bottom_row_o
);

  localparam int PROD_W = COEFF_WIDTH + COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int MAG_W  = ACC_W - 1;
  localparam int QW     = ppfc_pkg::QUOT_W;
  localparam int DIV_W  = MAG_W + QW;
  localparam int SW     = ppfc_pkg::SIZE_W;
  localparam int CMP_W  = ((COORD_WIDTH > ppfc_pkg::GROUND_W) ?
                           COORD_WIDTH : ppfc_pkg::GROUND_W) + 1;
  localparam logic [31:0] ROW_RST = 32'(ppfc_pkg::HEIGHT_RESET) - 32'd1;

  // point and products
  logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;
  logic                          kept_q;
  logic                          kept_d;
  logic [ppfc_pkg::REG_W-1:0]    col_word;
  logic signed [COORD_WIDTH-1:0] p_sel;
  logic signed [COEFF_WIDTH-1:0] m_sel;
  logic signed [PROD_W-1:0]      prod_d, prod_q;
  logic                          prod_vld_q;
  logic [1:0]                    prod_row_q;
  logic signed [COEFF_WIDTH-1:0] t_e [3];
  logic signed [ACC_W-1:0]       acc_q [3];

  // quotient lanes
  logic [MAG_W-1:0] rem_c_q, rem_r_q;
  logic [DIV_W-1:0] dvs_q, lim;
  logic [QW-1:0]    qc_q, qr_q;
  logic             ok_q, ok_d, ge_c, ge_r;

  // result
  logic                   fits_c, fits_r, view;
  logic [QW+PIXEL_WIDTH-1:0] qc_ext, qr_ext;
  logic [PIXEL_WIDTH-1:0] col_pix, row_pix;
  logic [PIXEL_WIDTH-1:0] min_row_q, max_row_q, min_row_d, max_row_d;
  logic [31:0]            hm1;
  logic                   out_valid_q;

  assign kept_d = !cfg_i.gf_on ||
                  ($signed(CMP_W'(pos_z_i)) >
                   $signed(CMP_W'($signed(cfg_i.ground))));

  always_comb begin
    case (cmd_i.mul_col)
      2'd0: begin
        col_word = cfg_i.coeff[0];
        p_sel    = px_q;
      end
      2'd1: begin
        col_word = cfg_i.coeff[1];
        p_sel    = py_q;
      end
      2'd2: begin
        col_word = cfg_i.coeff[2];
        p_sel    = pz_q;
      end
      default: begin
        col_word = cfg_i.coeff[0];
        p_sel    = px_q;
      end
    endcase
    case (cmd_i.mul_row)
      2'd0:    m_sel = col_word[COEFF_WIDTH-1:0];
      2'd1:    m_sel = col_word[2*COEFF_WIDTH-1:COEFF_WIDTH];
      2'd2:    m_sel = col_word[3*COEFF_WIDTH-1:2*COEFF_WIDTH];
      default: m_sel = col_word[COEFF_WIDTH-1:0];
    endcase
    prod_d = PROD_W'(m_sel) * PROD_W'(p_sel);
    for (int r = 0; r < 3; r++) begin
      t_e[r] = cfg_i.offset[r*COEFF_WIDTH +: COEFF_WIDTH];
    end
  end

  assign lim  = {acc_q[2][MAG_W-1:0], {QW{1'b0}}};
  assign ok_d = !acc_q[2][ACC_W-1] && (acc_q[2] != '0) &&
                !acc_q[0][ACC_W-1] && !acc_q[1][ACC_W-1] &&
                (DIV_W'(acc_q[0][MAG_W-1:0]) < lim) &&
                (DIV_W'(acc_q[1][MAG_W-1:0]) < lim);
  assign ge_c = DIV_W'(rem_c_q) >= dvs_q;
  assign ge_r = DIV_W'(rem_r_q) >= dvs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      kept_q <= kept_d;
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= ACC_W'(t_e[r]) <<< 10;
      end
    end else if (prod_vld_q) begin
      acc_q[prod_row_q] <= acc_q[prod_row_q] + ACC_W'(prod_q);
    end
    if (cmd_i.mul_en) begin
      prod_q     <= prod_d;
      prod_row_q <= cmd_i.mul_row;
    end
    if (cmd_i.div_init) begin
      rem_c_q <= acc_q[0][MAG_W-1:0];
      rem_r_q <= acc_q[1][MAG_W-1:0];
      dvs_q   <= DIV_W'({acc_q[2][MAG_W-1:0], {(QW-1){1'b0}}});
      qc_q    <= '0;
      qr_q    <= '0;
      ok_q    <= ok_d;
    end else if (cmd_i.div_step) begin
      if (ge_c) rem_c_q <= MAG_W'(DIV_W'(rem_c_q) - dvs_q);
      if (ge_r) rem_r_q <= MAG_W'(DIV_W'(rem_r_q) - dvs_q);
      qc_q  <= {qc_q[QW-2:0], ge_c};
      qr_q  <= {qr_q[QW-2:0], ge_r};
      dvs_q <= dvs_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  assign fits_c  = ((SW+1)'(qc_q) + (SW+1)'(1)) < (SW+1)'(cfg_i.width);
  assign fits_r  = ((SW+1)'(qr_q) + (SW+1)'(1)) < (SW+1)'(cfg_i.height);
  assign view    = kept_q && ok_q && fits_c && fits_r;
  assign qc_ext  = {{PIXEL_WIDTH{1'b0}}, qc_q};
  assign qr_ext  = {{PIXEL_WIDTH{1'b0}}, qr_q};
  assign col_pix = view ? qc_ext[PIXEL_WIDTH-1:0] : '0;
  assign row_pix = view ? qr_ext[PIXEL_WIDTH-1:0] : '0;
  assign min_row_d = (view && (row_pix < min_row_q)) ? row_pix : min_row_q;
  assign max_row_d = (view && (row_pix > max_row_q)) ? row_pix : max_row_q;
  assign hm1       = 32'(cfg_i.height) - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_row_q   <= ROW_RST[PIXEL_WIDTH-1:0];
      max_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        min_row_q <= hm1[PIXEL_WIDTH-1:0];
        max_row_q <= '0;
      end else if (cmd_i.finish) begin
        min_row_q <= min_row_d;
        max_row_q <= max_row_d;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      kept_o       <= kept_q;
      in_view_o    <= view;
      pixel_col_o  <= col_pix;
      pixel_row_o  <= row_pix;
      top_row_o    <= min_row_d;
      bottom_row_o <= max_row_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// File: src/point_projection_frustum_cull_top.sv
// top level: lidar point ground filter, pinhole projection and image bounds test
// a point is loaded in idle, then passes the multiply-accumulate, divide setup,
// divide and finish states; one point is in work at a time, on the shared multiplier
// (9 steps plus one drain) and the 13-step restoring quotient loop for column and row
// a finished result waits in the output register while the next point is taken
// reset: asynchronous active low; configuration registers return to their defaults, rows restart
module point_projection_frustum_cull_top #(
  parameter int COORD_WIDTH = 16,
  parameter int COEFF_WIDTH = 21,
  parameter int PIXEL_WIDTH = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // pos_x, pos_y, pos_z
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // pixel_col, pixel_row, top_row, bottom_row
  output logic [((4*PIXEL_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,
  // kept, in_view
  output logic [1:0]                             m_axis_tuser_o,
  input  logic                                   cfg_we_i,
  input  logic [ppfc_pkg::IDX_W-1:0]             cfg_idx_i,
  input  logic [ppfc_pkg::REG_W-1:0]             cfg_data_i
);

  localparam int OUT_W = ((4*PIXEL_WIDTH+7)/8)*8;

  ppfc_pkg::cfg_t    cfg;
  logic              restart;
  ppfc_pkg::cmd_t    cmd;
  ppfc_pkg::status_t status;
  logic              out_kept, out_view;
  logic [PIXEL_WIDTH-1:0] out_col, out_row, out_top, out_bottom;

  ppfc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .restart_o  (restart)
  );

  ppfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppfc_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH),
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (restart),
    .cmd_i        (cmd),
    .status_o     (status),
    .pos_x_i      (s_axis_tdata_i[COORD_WIDTH-1:0]),
    .pos_y_i      (s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pos_z_i      (s_axis_tdata_i[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .kept_o       (out_kept),
    .in_view_o    (out_view),
    .pixel_col_o  (out_col),
    .pixel_row_o  (out_row),
    .top_row_o    (out_top),
    .bottom_row_o (out_bottom)
  );

  assign m_axis_tdata_o = OUT_W'({out_bottom, out_top, out_row, out_col});
  assign m_axis_tuser_o = {out_view, out_kept};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while a point is in work");

  a_view_needs_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_view) |-> out_kept)
    else $error("point in view but not kept");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_view) |-> (out_top <= out_row && out_row <= out_bottom))
    else $error("row outside tracked row range");

  a_blank_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_view) |-> (out_col == '0 && out_row == '0))
    else $error("pixel not cleared for point out of view");

endmodule
